// File: design/vsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsm_pkg
// Shared types and constants of the voxel set membership block.
// ----------------------------------------------------------------------------
package vsm_pkg;

    localparam int CODE_W  = 63;
    localparam int COORD_W = 21;

    typedef enum logic [1:0] {
        KIND_REF   = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef logic [CODE_W-1:0] code_t;

endpackage

// File: design/vsm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsm_if
// Point channel and result channel of the voxel set membership block.
// ----------------------------------------------------------------------------
interface vsm_point_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [20:0] coord_a;
    logic [20:0] coord_b;
    logic [20:0] coord_c;
    logic        last;

    modport source (output valid, kind, coord_a, coord_b, coord_c, last, input ready);
    modport sink (input valid, kind, coord_a, coord_b, coord_c, last, output ready);
endinterface

interface vsm_result_if;
    logic valid;
    logic ready;
    logic found;
    logic no_set;
    logic overflow;

    modport source (output valid, found, no_set, overflow, input ready);
    modport sink (input valid, found, no_set, overflow, output ready);
endinterface

// File: design/voxel_set_membership_top.sv
`timescale 1ns / 1ps
// query on an open set goes straight to the output register; on a closed one a binary
// search over the stored codes runs first; the point port is ready again once it is output
// reference point: shifts each larger stored entry up one slot, from the end down, and
// writes its code into its sorted place; clear, kind 3 and dropped points leave it idle
// search and insertion share the single store read port; a full output register holds the query
// reset (async, active low) empties the set and clears the closed and dropped flags
// ----------------------------------------------------------------------------
// voxel_set_membership_top
// Sorted Morton-code store with insertion on load and binary search on query.
// ----------------------------------------------------------------------------
module voxel_set_membership_top
    import vsm_pkg::*;
#(
    parameter int REF_DEPTH  = 4096,
    parameter int COORD_BITS = 21
)
(
    input  logic          clk,
    input  logic          rst_n,
    vsm_point_if.sink     req,
    vsm_result_if.source  rsp
);

    localparam int AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int CW = $clog2(REF_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_QRY_RD,
        ST_QRY_CMP,
        ST_QRY_EQ,
        ST_OUT
    } state_t;

    state_t        state_reg;
    code_t         code_reg;
    logic [CW-1:0] count_reg;
    logic          closed_reg;
    logic          dropped_reg;
    logic          last_reg;
    logic [AW-1:0] idx_reg;
    logic [CW-1:0] lo_reg;
    logic [CW-1:0] hi_reg;
    logic          found_reg;
    logic          no_set_reg;
    logic          out_valid_reg;
    logic          res_found_reg;
    logic          res_no_set_reg;
    logic          res_overflow_reg;

    code_t         code_next;
    logic [CW-1:0] mid_full;
    logic [AW-1:0] mid;
    logic [CW-1:0] count_eff;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    code_t         mem_wdata;
    logic [AW-1:0] mem_raddr;
    code_t         mem_rdata;
    logic          accept;

    // bit interleave, c lowest
    always_comb
    begin
        code_next = '0;
        for (int i = 0; i < COORD_W; i++)
        begin
            if (i < COORD_BITS)
            begin
                code_next[3*i]   = req.coord_c[i];
                code_next[3*i+1] = req.coord_b[i];
                code_next[3*i+2] = req.coord_a[i];
            end
        end
    end

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign count_eff = closed_reg ? '0 : count_reg;
    assign mid_full  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid       = mid_full[AW-1:0];

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = code_reg;
        mem_raddr = idx_reg - AW'(1);
        case (state_reg)
            ST_INS_RD:
            begin
                mem_we = (idx_reg == '0);
            end
            ST_INS_CMP:
            begin
                mem_we = 1'b1;
                if (mem_rdata > code_reg)
                begin
                    mem_wdata = mem_rdata;
                end
            end
            ST_QRY_RD:
            begin
                mem_raddr = (lo_reg < hi_reg) ? mid : lo_reg[AW-1:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    vsm_ram #(
        .DEPTH (REF_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            closed_reg       <= 1'b0;
            dropped_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            last_reg         <= 1'b0;
            code_reg         <= '0;
            idx_reg          <= '0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            found_reg        <= 1'b0;
            no_set_reg       <= 1'b0;
            res_found_reg    <= 1'b0;
            res_no_set_reg   <= 1'b0;
            res_overflow_reg <= 1'b0;
        end
        else
        begin
            if (rsp.ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        code_reg <= code_next;
                        last_reg <= req.last;
                        case (kind_t'(req.kind))
                            KIND_REF:
                            begin
                                if (closed_reg)
                                begin
                                    closed_reg  <= 1'b0;
                                    dropped_reg <= 1'b0;
                                    count_reg   <= '0;
                                end
                                if (count_eff < CW'(REF_DEPTH))
                                begin
                                    idx_reg   <= count_eff[AW-1:0];
                                    state_reg <= ST_INS_RD;
                                end
                                else
                                begin
                                    dropped_reg <= 1'b1;
                                    if (req.last)
                                    begin
                                        closed_reg <= 1'b1;
                                    end
                                end
                            end
                            KIND_QUERY:
                            begin
                                found_reg  <= 1'b0;
                                no_set_reg <= !closed_reg;
                                lo_reg     <= '0;
                                hi_reg     <= count_reg;
                                state_reg  <= closed_reg ? ST_QRY_RD : ST_OUT;
                            end
                            KIND_CLEAR:
                            begin
                                closed_reg  <= 1'b0;
                                dropped_reg <= 1'b0;
                                count_reg   <= '0;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_INS_RD:
                begin
                    // slot zero reached: the write happens this cycle
                    if (idx_reg == '0)
                    begin
                        count_reg  <= count_reg + CW'(1);
                        closed_reg <= last_reg;
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_INS_CMP;
                    end
                end
                ST_INS_CMP:
                begin
                    if (mem_rdata > code_reg)
                    begin
                        idx_reg   <= idx_reg - AW'(1);
                        state_reg <= ST_INS_RD;
                    end
                    else
                    begin
                        count_reg  <= count_reg + CW'(1);
                        closed_reg <= last_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                ST_QRY_RD:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        idx_reg   <= mid;
                        state_reg <= ST_QRY_CMP;
                    end
                    else if (lo_reg < count_reg)
                    begin
                        state_reg <= ST_QRY_EQ;
                    end
                    else
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_QRY_CMP:
                begin
                    if (mem_rdata < code_reg)
                    begin
                        lo_reg <= CW'(idx_reg) + CW'(1);
                    end
                    else
                    begin
                        hi_reg <= CW'(idx_reg);
                    end
                    state_reg <= ST_QRY_RD;
                end
                ST_QRY_EQ:
                begin
                    found_reg <= (mem_rdata == code_reg);
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg    <= 1'b1;
                        res_found_reg    <= found_reg;
                        res_no_set_reg   <= no_set_reg;
                        res_overflow_reg <= dropped_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.found    = res_found_reg;
    assign rsp.no_set   = res_no_set_reg;
    assign rsp.overflow = res_overflow_reg;

endmodule

// File: design/vsm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsm_ram
// Code store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vsm_ram
    import vsm_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  code_t         wdata,
    input  logic [AW-1:0] raddr,
    output code_t         rdata
);

    code_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives reference points, target queries, clears and unused kinds into the
// voxel set membership block with random gaps and receiver stalls, keeps a
// membership table of the loaded Morton codes and checks every result word.
// ----------------------------------------------------------------------------
module tb;
    import vsm_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam int IDLE_LIMIT  = 60000;
    localparam int LONG_HOLD   = 400;
    localparam int RANDOM_WORDS = 650;
    localparam int ASCEND_WORDS = 40;

    typedef struct {
        kind_t       kind;
        logic [20:0] a;
        logic [20:0] b;
        logic [20:0] c;
        logic        last;
    } point_t;

    typedef struct {
        logic found;
        logic no_set;
        logic overflow;
    } answer_t;

    class membership_board;
        code_t   set_codes[$];
        bit      closed;
        bit      dropped;
        answer_t pending[$];
        int      errors;

        function code_t interleave(logic [20:0] a, logic [20:0] b, logic [20:0] c);
            code_t code;
            code = '0;
            for (int i = 0; i < COORD_W; i++)
            begin
                code[3*i]   = c[i];
                code[3*i+1] = b[i];
                code[3*i+2] = a[i];
            end
            return code;
        endfunction

        function bit holds(code_t code);
            foreach (set_codes[i])
                if (set_codes[i] == code)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void note_point(point_t p);
            answer_t ans;
            code_t   code;
            code = interleave(p.a, p.b, p.c);
            case (p.kind)
                KIND_REF:
                begin
                    if (closed)
                    begin
                        set_codes.delete();
                        closed  = 1'b0;
                        dropped = 1'b0;
                    end
                    if (set_codes.size() < STORE_DEPTH)
                        set_codes.push_back(code);
                    else
                        dropped = 1'b1;
                    if (p.last)
                        closed = 1'b1;
                end
                KIND_QUERY:
                begin
                    ans.found    = closed && holds(code);
                    ans.no_set   = !closed;
                    ans.overflow = dropped;
                    pending.push_back(ans);
                end
                KIND_CLEAR:
                begin
                    set_codes.delete();
                    closed  = 1'b0;
                    dropped = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void check_answer(logic found, logic no_set, logic overflow);
            answer_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word found=%b no_set=%b overflow=%b",
                             found, no_set, overflow);
                return;
            end
            want = pending.pop_front();
            if (found !== want.found || no_set !== want.no_set ||
                overflow !== want.overflow)
            begin
                errors++;
                if (errors <= 10)
                    $display({"result mismatch: expected found=%b no_set=%b ",
                              "overflow=%b, got %b %b %b"},
                             want.found, want.no_set, want.overflow, found, no_set, overflow);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   hold_request;
    bit   held;
    int   sent;
    membership_board board;

    vsm_point_if  pin();
    vsm_result_if rin();

    voxel_set_membership_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pin.sink),
        .rsp   (rin.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        // at least a quarter of the words go back to back
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    function automatic point_t make_point(kind_t k, logic [20:0] a, logic [20:0] b,
                                          logic [20:0] c, logic last);
        point_t p;
        p.kind = k;
        p.a    = a;
        p.b    = b;
        p.c    = c;
        p.last = last;
        return p;
    endfunction

    function automatic point_t random_point(kind_t k, logic last);
        return make_point(k, 21'($urandom), 21'($urandom), 21'($urandom), last);
    endfunction

    task automatic send_point(point_t p, bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0)
        begin
            pin.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pin.valid   <= 1'b1;
        pin.kind    <= p.kind;
        pin.coord_a <= p.a;
        pin.coord_b <= p.b;
        pin.coord_c <= p.c;
        pin.last    <= p.last;
        do
            @(posedge clk);
        while (!pin.ready);
        board.note_point(p);
        sent++;
    endtask

    // receiver with random stalls and one long hold-off on request
    initial
    begin
        int gap;
        rin.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                rin.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                rin.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rin.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rin.valid);
            board.check_answer(rin.found, rin.no_set, rin.overflow);
        end
    end

    // watchdog on cycles with no word moving on either channel
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((pin.valid && pin.ready) || (rin.valid && rin.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
                break;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic query_set(point_t refs[$], int n);
        point_t q;
        for (int i = 0; i < n; i++)
        begin
            if (refs.size() > 0 && $urandom_range(0, 9) < 6)
            begin
                q = refs[$urandom_range(0, refs.size() - 1)];
                q.kind = KIND_QUERY;
                q.last = 1'($urandom);
            end
            else
                q = random_point(KIND_QUERY, 1'($urandom));
            send_point(q, 1'b0);
        end
    endtask

    task automatic load_set(int n, output point_t refs[$]);
        point_t p;
        refs.delete();
        for (int i = 0; i < n; i++)
        begin
            if (refs.size() > 0 && $urandom_range(0, 9) == 0)
                p = refs[$urandom_range(0, refs.size() - 1)];
            else
                p = random_point(KIND_REF, 1'b0);
            // now and then close early, or query the still open set
            p.last = (i == n - 1) || ($urandom_range(0, 19) == 0);
            refs.push_back(p);
            send_point(p, 1'b0);
            if ($urandom_range(0, 14) == 0)
                send_point(random_point(KIND_QUERY, 1'($urandom)), 1'b0);
        end
    endtask

    initial
    begin
        point_t refs[$];
        point_t p;
        int     pick;
        logic [20:0] ones;
        logic [20:0] alt;

        board = new();
        ones = '1;
        alt  = 21'h0AAAAA;
        sent = 0;
        hold_request = 1'b0;
        held = 1'b0;
        pin.valid = 1'b0;
        pin.kind = KIND_REF;
        pin.coord_a = '0;
        pin.coord_b = '0;
        pin.coord_c = '0;
        pin.last = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: query with no set, extreme points, kind 3, clear, reopen
        send_point(make_point(KIND_QUERY, '0, '0, '0, 1'b0), 1'b0);
        send_point(make_point(KIND_REF, '0, '0, '0, 1'b0), 1'b0);
        send_point(make_point(KIND_QUERY, '0, '0, '0, 1'b1), 1'b0);
        send_point(make_point(KIND_REF, ones, ones, ones, 1'b0), 1'b0);
        send_point(make_point(KIND_REF, alt, ~alt, alt, 1'b0), 1'b0);
        send_point(make_point(KIND_REF, ones, ones, ones, 1'b0), 1'b0);
        send_point(make_point(KIND_REF, 21'h000001, 21'h100000, 21'd42, 1'b1), 1'b0);
        send_point(make_point(KIND_QUERY, '0, '0, '0, 1'b0), 1'b0);
        send_point(make_point(KIND_QUERY, ones, ones, ones, 1'b1), 1'b0);
        send_point(make_point(KIND_QUERY, alt, ~alt, alt, 1'b0), 1'b0);
        send_point(make_point(KIND_QUERY, ~alt, alt, ~alt, 1'b0), 1'b0);
        send_point(make_point(KIND_QUERY, 21'h000001, 21'h100000, 21'd42, 1'b0), 1'b0);
        send_point(make_point(KIND_QUERY, 21'h100000, 21'h000001, 21'd42, 1'b0), 1'b0);
        send_point(make_point(KIND_NONE, ones, ones, ones, 1'b1), 1'b0);
        send_point(make_point(KIND_QUERY, ones, ones, ones, 1'b0), 1'b0);
        send_point(make_point(KIND_CLEAR, ones, '0, ones, 1'b1), 1'b0);
        send_point(make_point(KIND_QUERY, ones, ones, ones, 1'b0), 1'b0);
        send_point(make_point(KIND_REF, 21'd5, 21'd6, 21'd7, 1'b1), 1'b0);
        // a reference point on a closed set begins a new one
        send_point(make_point(KIND_REF, 21'd9, 21'd9, 21'd9, 1'b1), 1'b0);
        send_point(make_point(KIND_QUERY, 21'd5, 21'd6, 21'd7, 1'b0), 1'b0);
        send_point(make_point(KIND_QUERY, 21'd9, 21'd9, 21'd9, 1'b0), 1'b0);

        // ascending codes: each insertion lands at the end of the store
        send_point(make_point(KIND_CLEAR, '0, '0, '0, 1'b0), 1'b0);
        for (int i = 0; i < ASCEND_WORDS; i++)
            send_point(make_point(KIND_REF, '0, '0, 21'(i),
                                  i == ASCEND_WORDS - 1), $urandom_range(0, 7) != 0);
        send_point(make_point(KIND_QUERY, '0, '0, 21'd0, 1'b0), 1'b0);
        send_point(make_point(KIND_QUERY, '0, '0, 21'(ASCEND_WORDS - 1), 1'b0), 1'b0);
        send_point(make_point(KIND_QUERY, '0, '0, 21'(ASCEND_WORDS), 1'b0), 1'b0);
        send_point(make_point(KIND_REF, ones, '0, '0, 1'b1), 1'b0);
        send_point(make_point(KIND_QUERY, ones, '0, '0, 1'b0), 1'b0);

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (sent > RANDOM_WORDS / 2 && !held && refs.size() > 0)
            begin
                // long receiver stall while queries keep coming
                held = 1'b1;
                hold_request = 1'b1;
                for (int i = 0; i < 30; i++)
                begin
                    p = refs[$urandom_range(0, refs.size() - 1)];
                    p.kind = KIND_QUERY;
                    send_point(p, 1'b1);
                end
            end
            pick = $urandom_range(0, 9);
            if (pick <= 6)
            begin
                load_set(($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 12), refs);
                query_set(refs, $urandom_range(1, 15));
            end
            else if (pick == 7)
            begin
                send_point(random_point(KIND_CLEAR, 1'($urandom)), 1'b0);
                query_set(refs, $urandom_range(0, 3));
            end
            else if (pick == 8)
            begin
                send_point(random_point(KIND_NONE, 1'($urandom)), 1'b0);
                query_set(refs, $urandom_range(1, 4));
            end
            else
                query_set(refs, $urandom_range(1, 6));
        end
        pin.valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: voxel_set_membership_top.f
design/vsm_pkg.sv
design/vsm_if.sv
design/vsm_ram.sv
design/voxel_set_membership_top.sv
tb/tb.sv
